FILE: hdl/wres_pkg.sv
// ---------------------------------------------------------------------------
// wres_pkg
// Shared widths, constants and helpers of the weighted random entry select.
// ---------------------------------------------------------------------------
package wres_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    // running sums over at most sixteen enabled 32-bit weights
    localparam int SUM_W = 36;
    localparam int MUL_AW = 36;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int DIV_W = 40;
    localparam int DIV_CW = 6;

    localparam logic [31:0] FLOOR_Q16 = 32'd66;
    localparam logic [16:0] DECAY_ONE = 17'h10000;
    localparam logic [DIV_W-1:0] RESCALE_NUM = DIV_W'(100) << 32;

    // total / 1000 as (total * 35184372089) >> 45, exact for totals below 2^36;
    // the multiplier takes the low 32 bits of the constant, the 8 * 2^32 part is a shift
    localparam logic [MUL_BW-1:0] SLOP_RECIP_LO = 32'd824633721;
    localparam int SLOP_HI_SH = 35;
    localparam int SLOP_SH = 45;

    // configuration register indexes
    localparam logic [1:0] CFG_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_MASK = 2'd1;
    localparam logic [1:0] CFG_DYNAMIC = 2'd2;
    localparam logic [1:0] CFG_DECAY = 2'd3;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    function automatic logic entry_en(input logic [15:0] mask, input logic [7:0] idx);
        entry_en = (idx < 8'd16) && mask[idx[3:0]];
    endfunction

endpackage

FILE: hdl/wres_mul.sv
// ---------------------------------------------------------------------------
// wres_mul
// Shared multiplier with a registered product.
// ---------------------------------------------------------------------------
module wres_mul (
    input  logic                       i_clk,
    input  logic [wres_pkg::MUL_AW-1:0] i_a,
    input  logic [wres_pkg::MUL_BW-1:0] i_b,
    output logic [wres_pkg::MUL_PW-1:0] o_prod
);
    import wres_pkg::*;

    logic [MUL_PW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_PW'(i_a) * MUL_PW'(i_b);
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/wres_div.sv
// ---------------------------------------------------------------------------
// wres_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wres_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wres_pkg::DIV_W-1:0] i_dividend,
    input  logic [wres_pkg::SUM_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [wres_pkg::DIV_W-1:0] o_quot
);
    import wres_pkg::*;

    logic [SUM_W:0]    r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [SUM_W-1:0]  r_dvs;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [SUM_W:0]    n_shift;
    logic [SUM_W+1:0]  n_diff;

    always_comb begin
        n_shift = {r_rem[SUM_W-1:0], r_quo[DIV_W-1]};
        n_diff  = {1'b0, n_shift} - {2'b00, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!n_diff[SUM_W+1]) begin
                r_rem <= n_diff[SUM_W:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: hdl/weighted_random_entry_select_core.sv
// ---------------------------------------------------------------------------
// weighted_random_entry_select_core
// Roulette wheel selection over a table of Q16.16 weights with adaptive decay.
// ---------------------------------------------------------------------------
// sequence: a load writes its weight and raises its result once taken; a select sums
//   the enabled weights, scales the random value to a point, computes the slop and scans
//   the entries; dynamic mode adds decay (when found), floor, rescale division (nonzero sum) and rescale
// throughput: one transaction at a time, the next is taken in the cycle after the
//   result is raised
// reset: synchronous active low, clears the sequencer state, output valid, config and weight valid bits
module weighted_random_entry_select_core #(
    parameter int MAX_ENTRIES = wres_pkg::MAX_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] entry_index, [35:4] weight_value, [50:36] random_value
    input  logic [55:0] s_axis_tdata,
    // [0] op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] found, [4:1] chosen_index
    output logic [7:0]  m_axis_tdata,
    // [0] was_select
    output logic        m_axis_tuser
);
    import wres_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_PNT  = 4'd2;
    localparam logic [3:0] S_SLOP = 4'd3;
    localparam logic [3:0] S_SCAN = 4'd4;
    localparam logic [3:0] S_DEC  = 4'd5;
    localparam logic [3:0] S_FLR  = 4'd6;
    localparam logic [3:0] S_SDIV = 4'd7;
    localparam logic [3:0] S_RSC  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // config
    logic [4:0]  r_eiu;
    logic [15:0] r_mask;
    logic        r_dyn;
    logic [16:0] r_decay;

    // weight memory with per-entry valid bits
    logic [31:0]          r_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_vld;
    logic [31:0]          r_rd_data;
    logic                 r_rd_vld;

    logic [3:0]       r_state;
    logic [1:0]       r_ph;
    logic [CW-1:0]    r_i;
    logic [CW-1:0]    r_n;
    logic             r_op;
    logic [14:0]      r_rnd;
    logic [SUM_W-1:0] r_total;
    logic [SUM_W-1:0] r_point;
    logic [SUM_W-1:0] r_slop;
    logic [SUM_W-1:0] r_cum;
    logic [31:0]      r_scale;
    logic             r_found;
    logic [3:0]       r_chosen;

    logic        r_ovalid;
    logic [7:0]  r_odata;
    logic        r_ouser;

    logic              w_we;
    logic [IW-1:0]     w_wa;
    logic [31:0]       w_wd;
    logic [31:0]       w_rdw;
    logic              w_en;
    logic              w_last;
    logic [MUL_AW-1:0] w_mul_a;
    logic [MUL_BW-1:0] w_mul_b;
    logic [MUL_PW-1:0] w_prod;
    logic [MUL_PW+3:0] w_slop_acc;
    logic              w_div_start;
    logic [DIV_W-1:0]  w_div_dnd;
    logic [SUM_W-1:0]  w_div_dvs;
    logic              w_div_done;
    logic [DIV_W-1:0]  w_quot;
    logic              w_acc;
    logic [3:0]        w_idx;
    logic [CW-1:0]     w_n;
    logic [16:0]       w_dsat;
    logic [31:0]       w_flr;
    logic [SUM_W-1:0]  w_cum_nx;
    logic              w_hit;

    assign w_idx = s_axis_tdata[3:0];
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    assign w_rdw  = r_rd_vld ? r_rd_data : 32'd0;
    assign w_en   = entry_en(r_mask, 8'(r_i));
    assign w_last = (CW'(r_i + 1'b1) == r_n);
    assign w_n    = (8'(r_eiu) > 8'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(r_eiu);
    assign w_dsat = (r_decay > DECAY_ONE) ? DECAY_ONE : r_decay;
    assign w_flr  = (!(r_found && (4'(r_i) == r_chosen)) && (w_rdw < FLOOR_Q16)) ?
                    FLOOR_Q16 : w_rdw;
    assign w_cum_nx = r_cum + SUM_W'(w_rdw);
    assign w_hit  = ({1'b0, w_cum_nx} + {1'b0, r_slop}) >= {1'b0, r_point};
    assign w_slop_acc = (MUL_PW+4)'(w_prod) + ((MUL_PW+4)'(r_total) << SLOP_HI_SH);

    wres_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    wres_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dnd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // memory write port, shared multiplier operands, divider launch
    always_comb begin
        w_we        = 1'b0;
        w_wa        = r_i[IW-1:0];
        w_wd        = w_rdw;
        w_mul_a     = MUL_AW'(w_rdw);
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_dnd   = RESCALE_NUM;
        w_div_dvs   = '0;
        case (r_state)
            S_IDLE: begin
                w_wa = IW'(w_idx);
                w_wd = s_axis_tdata[35:4];
                w_we = w_acc && (s_axis_tuser == OP_LOAD) &&
                       (8'(w_idx) < 8'(MAX_ENTRIES));
            end
            S_PNT: begin
                w_mul_a = r_total;
                w_mul_b = MUL_BW'(r_rnd);
            end
            S_SLOP: begin
                w_mul_a = r_total;
                w_mul_b = SLOP_RECIP_LO;
            end
            S_DEC: begin
                w_mul_b = MUL_BW'(w_dsat);
                w_wd    = w_prod[47:16];
                w_we    = (r_ph == 2'd2);
            end
            S_FLR: begin
                w_wd = w_flr;
                w_we = (r_ph == 2'd1) && w_en;
                w_div_start = (r_ph == 2'd1) && w_last && (w_cum_nx != '0 || w_en ?
                              ((w_en ? r_cum + SUM_W'(w_flr) : r_cum) != '0) : 1'b0);
                w_div_dnd = RESCALE_NUM;
                w_div_dvs = w_en ? r_cum + SUM_W'(w_flr) : r_cum;
            end
            S_RSC: begin
                w_mul_b = r_scale;
                w_wd    = (|w_prod[63:48]) ? 32'hFFFF_FFFF : w_prod[47:16];
                w_we    = (r_ph == 2'd2) && w_en;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[r_i[IW-1:0]];
        r_rd_vld  <= r_vld[r_i[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eiu   <= '0;
            r_mask  <= '0;
            r_dyn   <= 1'b0;
            r_decay <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENTRIES: r_eiu   <= i_cfg_data[4:0];
                CFG_MASK:    r_mask  <= i_cfg_data[15:0];
                CFG_DYNAMIC: r_dyn   <= i_cfg_data[0];
                CFG_DECAY:   r_decay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= '0;
            r_i      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_ph <= '0;
                    r_i  <= '0;
                    if (w_acc) begin
                        r_op     <= s_axis_tuser;
                        r_rnd    <= s_axis_tdata[50:36];
                        r_n      <= w_n;
                        r_found  <= 1'b0;
                        r_chosen <= '0;
                        r_total  <= '0;
                        r_cum    <= '0;
                        if (s_axis_tuser == OP_LOAD || w_n == '0) begin
                            r_state <= S_DONE;
                        end else if (w_n == CW'(1)) begin
                            r_found <= r_mask[0];
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (w_en) begin
                            r_total <= r_total + SUM_W'(w_rdw);
                        end
                        if (w_last) begin
                            r_state <= S_PNT;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_PNT: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph    <= 2'd0;
                        r_point <= w_prod[SUM_W+14:15];
                        r_state <= S_SLOP;
                    end
                end
                S_SLOP: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph    <= 2'd0;
                        r_slop  <= SUM_W'(w_slop_acc[MUL_PW+3:SLOP_SH]);
                        r_i     <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (w_en) begin
                            r_cum <= w_cum_nx;
                        end
                        if (w_en && w_hit) begin
                            r_found  <= 1'b1;
                            r_chosen <= 4'(r_i);
                            r_state  <= r_dyn ? S_DEC : S_DONE;
                        end else if (w_last) begin
                            r_i     <= '0;
                            r_state <= r_dyn ? S_FLR : S_DONE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_DEC: begin
                    if (r_ph == 2'd2) begin
                        r_ph    <= 2'd0;
                        r_i     <= '0;
                        r_cum   <= '0;
                        r_state <= S_FLR;
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_FLR: begin
                    if (r_ph == 2'd0) begin
                        r_ph  <= 2'd1;
                        if (r_i == '0) begin
                            r_cum <= '0;
                        end
                    end else begin
                        r_ph <= 2'd0;
                        if (w_en) begin
                            r_cum <= r_cum + SUM_W'(w_flr);
                        end
                        if (w_last) begin
                            r_i     <= '0;
                            r_state <= w_div_start ? S_SDIV : S_DONE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_SDIV: begin
                    if (w_div_done) begin
                        r_scale <= (|w_quot[DIV_W-1:32]) ? 32'hFFFF_FFFF : w_quot[31:0];
                        r_state <= S_RSC;
                    end
                end
                S_RSC: begin
                    if (r_ph == 2'd2) begin
                        r_ph <= 2'd0;
                        if (w_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ouser  <= r_op;
                        r_odata  <= {3'b000, (r_found ? r_chosen : 4'd0), r_found};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

FILE: hdl/wres_chk.sv
// ---------------------------------------------------------------------------
// wres_chk
// Port-level checks of the weighted random entry select, bound to the core.
// ---------------------------------------------------------------------------
module wres_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // nothing is shown right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one transaction in flight at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // load results carry no selection
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
        else $error("load result not zero");

    // index is zero when nothing was found
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[4:1] == 4'd0)
        else $error("index without found");

endmodule

bind weighted_random_entry_select_core wres_chk u_wres_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
